### hdl/mrc_pkg.sv
// Shared types, constants and helper functions for the maze carver.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int MAX_SIZE    = 63;
    localparam int ROOM_DIM    = (MAX_SIZE - 1) / 2;
    localparam int STACK_DEPTH = ROOM_DIM * ROOM_DIM;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int ROOM_AW     = $clog2(ROOM_DIM);
    localparam int CELL_AW     = $clog2(MAX_SIZE);
    localparam int MIN_SIZE    = 5;
    localparam int RESET_SIZE  = 21;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_NEXT  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [2:0] SLOTS_DONE = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [14:0] rand_first;
        logic [14:0] rand_second;
        logic [14:0] rand_third;
        logic [5:0]  read_row;
        logic [5:0]  read_col;
    } req_t;

    typedef struct packed {
        logic [5:0] wall_row;
        logic [5:0] wall_col;
        logic [5:0] room_row;
        logic [5:0] room_col;
        logic       carved;
        logic       finished;
        logic       cell_is_wall;
    } rsp_t;

    // One stack entry: room position, shuffled direction order, next slot.
    typedef struct packed {
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] order;
        logic [2:0] nxt;
    } stk_entry_t;

    typedef struct packed {
        logic                we;
        logic [STACK_AW-1:0] waddr;
        stk_entry_t          wdata;
        logic [STACK_AW-1:0] raddr;
    } stk_req_t;

    // Remainder by three: base-4 digits are folded, since four is one mod three.
    function automatic logic [1:0] mod3(input logic [14:0] x);
        logic [15:0] w;
        logic [4:0]  s1;
        logic [2:0]  s2;
        logic [2:0]  s3;
        w  = {1'b0, x};
        s1 = 5'(w[1:0]) + 5'(w[3:2]) + 5'(w[5:4]) + 5'(w[7:6])
           + 5'(w[9:8]) + 5'(w[11:10]) + 5'(w[13:12]) + 5'(w[15:14]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // Fisher-Yates shuffle of the four directions; slot i sits at bits 2i+1:2i.
    function automatic logic [7:0] shuffle(input logic [14:0] ra, input logic [14:0] rb,
                                           input logic [14:0] rc);
        logic [1:0] o [4];
        logic [1:0] t;
        logic [1:0] a;
        logic [1:0] b;
        o[0] = DIR_UP;
        o[1] = DIR_DOWN;
        o[2] = DIR_LEFT;
        o[3] = DIR_RIGHT;
        a    = ra[1:0];
        t    = o[3];
        o[3] = o[a];
        o[a] = t;
        b    = mod3(rb);
        t    = o[2];
        o[2] = o[b];
        o[b] = t;
        // An even draw swaps slot 1 with slot 0; an odd one leaves it in place.
        if (!rc[0]) begin
            t    = o[1];
            o[1] = o[0];
            o[0] = t;
        end
        return {o[3], o[2], o[1], o[0]};
    endfunction

endpackage

### hdl/mrc_stack.sv
// Room stack memory: one write port and one registered read port.
`timescale 1ns / 1ps

module mrc_stack (
    input  logic                 clk,
    input  mrc_pkg::stk_req_t    ctl,
    output mrc_pkg::stk_entry_t  rd_data
);

    mrc_pkg::stk_entry_t mem [0:mrc_pkg::STACK_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_data <= mem[ctl.raddr];
    end

endmodule

### hdl/random_maze_carver.sv
// Top level of the depth-first maze carver with its sequencer and maps.
`timescale 1ns / 1ps

//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------
//  req     | in        | req_valid/req_ready | mrc_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_ready | mrc_pkg::rsp_t
//  cfg     | in        | cfg_we, no wait     | 6-bit maze_size
//
//  A start word is handled in the idle state, a read word also in the
//  cell-read state. A next word enters the check state, then the visit state
//  per direction tried inside the grid, the check state again per one outside
//  and the pop-read state per room popped from beneath another, and ends in
//  the carve state or in the check that reports finished.
//  Reset clears the stack level and the row valid bits of both maps, so no
//  clearing pass is needed; a start word clears the same valid bits at once.
//  The block takes a new word only when it is idle and its result register
//  is empty; a stalled result holds the block in that state.

module random_maze_carver (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mrc_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mrc_pkg::rsp_t  rsp,
    input  logic           cfg_we,
    input  logic [5:0]     cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_POPRD  = 3'd2;
    localparam logic [2:0] S_VIS    = 3'd3;
    localparam logic [2:0] S_CARVE  = 3'd4;
    localparam logic [2:0] S_RDCELL = 3'd5;

    localparam int RA = mrc_pkg::ROOM_AW;
    localparam int CA = mrc_pkg::CELL_AW;
    localparam int SA = mrc_pkg::STACK_AW;

    // Control state.
    logic [2:0]                    state_reg, state_next;
    logic [SA:0]                   level_reg, level_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [mrc_pkg::ROOM_DIM-1:0]  vis_vld_reg, vis_vld_next;
    logic [mrc_pkg::MAX_SIZE-1:0]  cv_vld_reg, cv_vld_next;
    logic                          started_reg, started_next;
    logic [5:0]                    size_reg;

    // Payload registers.
    mrc_pkg::req_t                 req_reg, req_next;
    mrc_pkg::rsp_t                 rsp_reg, rsp_next;
    mrc_pkg::stk_entry_t           top_reg, top_next;
    logic [5:0]                    nstart_reg, nstart_next;
    logic [5:0]                    nr_reg, nr_next;
    logic [5:0]                    nc_reg, nc_next;
    logic [5:0]                    wr_reg, wr_next;
    logic [5:0]                    wc_reg, wc_next;

    // Visited-room map and carved-wall map, one row per word.
    logic [mrc_pkg::ROOM_DIM-1:0]  vis_mem [0:mrc_pkg::ROOM_DIM-1];
    logic [mrc_pkg::ROOM_DIM-1:0]  vis_q, vis_wdata;
    logic [RA-1:0]                 vis_raddr, vis_waddr;
    logic                          vis_we;
    logic [mrc_pkg::MAX_SIZE-1:0]  cv_mem [0:mrc_pkg::MAX_SIZE-1];
    logic [mrc_pkg::MAX_SIZE-1:0]  cv_q, cv_wdata;
    logic [CA-1:0]                 cv_raddr, cv_waddr;
    logic                          cv_we;

    mrc_pkg::stk_req_t             stk_ctl;
    mrc_pkg::stk_entry_t           stk_q;

    logic [5:0]                    n;
    logic                          accept;
    logic [1:0]                    dir;
    logic                          dir_ok;
    logic [5:0]                    cand_r, cand_c, cand_wr, cand_wc;
    logic                          vis_hit;
    logic                          room_open, wall_open;

    mrc_stack u_stack (
        .clk     (clk),
        .ctl     (stk_ctl),
        .rd_data (stk_q)
    );

    // The grid size is read live; anything below the minimum acts as the minimum.
    assign n         = (size_reg < 6'(mrc_pkg::MIN_SIZE)) ? 6'(mrc_pkg::MIN_SIZE) : size_reg;
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Shared step unit: the direction in the current slot of the top room,
    // its bounds test and the wall and room positions it leads to.
    always_comb
    begin
        dir     = top_reg.order[2*top_reg.nxt[1:0] +: 2];
        dir_ok  = 1'b0;
        cand_r  = top_reg.row;
        cand_c  = top_reg.col;
        cand_wr = top_reg.row;
        cand_wc = top_reg.col;
        unique case (dir)
            mrc_pkg::DIR_UP:
            begin
                dir_ok  = top_reg.row >= 6'd3;
                cand_r  = top_reg.row - 6'd2;
                cand_wr = top_reg.row - 6'd1;
            end
            mrc_pkg::DIR_DOWN:
            begin
                dir_ok  = ({1'b0, top_reg.row} + 7'd4) <= {1'b0, n};
                cand_r  = top_reg.row + 6'd2;
                cand_wr = top_reg.row + 6'd1;
            end
            mrc_pkg::DIR_LEFT:
            begin
                dir_ok  = top_reg.col >= 6'd3;
                cand_c  = top_reg.col - 6'd2;
                cand_wc = top_reg.col - 6'd1;
            end
            default:
            begin
                dir_ok  = ({1'b0, top_reg.col} + 7'd4) <= {1'b0, n};
                cand_c  = top_reg.col + 6'd2;
                cand_wc = top_reg.col + 6'd1;
            end
        endcase
    end

    // A room is visited when its row has been written since the last start and its bit is set.
    assign vis_hit = vis_vld_reg[nr_reg[RA:1]] && vis_q[nc_reg[RA:1]];

    // A cell reads open if it is a room of the last start or a carved wall.
    assign room_open = started_reg && req_reg.read_row[0] && req_reg.read_col[0]
                     && (({1'b0, req_reg.read_row} + 7'd2) <= {1'b0, nstart_reg})
                     && (({1'b0, req_reg.read_col} + 7'd2) <= {1'b0, nstart_reg});
    assign wall_open = cv_vld_reg[req_reg.read_row] && cv_q[req_reg.read_col];

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        rsp_valid_next = rsp_valid_reg;
        vis_vld_next   = vis_vld_reg;
        cv_vld_next    = cv_vld_reg;
        started_next   = started_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        top_next       = top_reg;
        nstart_next    = nstart_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        wr_next        = wr_reg;
        wc_next        = wc_reg;
        vis_raddr      = nr_reg[RA:1];
        vis_we         = 1'b0;
        vis_waddr      = nr_reg[RA:1];
        vis_wdata      = vis_q;
        cv_raddr       = wr_reg;
        cv_we          = 1'b0;
        cv_waddr       = wr_reg;
        cv_wdata       = cv_q;
        stk_ctl.we     = 1'b0;
        stk_ctl.waddr  = SA'(level_reg - 1'b1);
        stk_ctl.wdata  = top_reg;
        stk_ctl.raddr  = SA'(level_reg - 2'd2);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    rsp_next = '0;
                    cv_raddr = req.read_row;
                    unique case (req.req_type)
                        mrc_pkg::REQ_START:
                        begin
                            // Fresh maze: forget all visits and carvings,
                            // then enter the corner room.
                            vis_vld_next    = '0;
                            vis_vld_next[0] = 1'b1;
                            cv_vld_next     = '0;
                            vis_we          = 1'b1;
                            vis_waddr       = '0;
                            vis_wdata       = mrc_pkg::ROOM_DIM'(1);
                            started_next    = 1'b1;
                            nstart_next     = n;
                            level_next      = (SA+1)'(1);
                            top_next.row    = 6'd1;
                            top_next.col    = 6'd1;
                            top_next.order  = mrc_pkg::shuffle(req.rand_first,
                                                  req.rand_second, req.rand_third);
                            top_next.nxt    = '0;
                            rsp_next.room_row = 6'd1;
                            rsp_next.room_col = 6'd1;
                            rsp_valid_next  = 1'b1;
                        end
                        mrc_pkg::REQ_NEXT:
                        begin
                            state_next = S_CHECK;
                        end
                        mrc_pkg::REQ_READ:
                        begin
                            state_next = S_RDCELL;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (level_reg == '0)
                begin
                    rsp_next.finished = 1'b1;
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (top_reg.nxt == mrc_pkg::SLOTS_DONE)
                begin
                    // Exhausted room: pop it and fetch the one below.
                    level_next = level_reg - 1'b1;
                    if (level_reg == 1)
                    begin
                        rsp_next.finished = 1'b1;
                        rsp_valid_next    = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POPRD;
                    end
                end
                else
                begin
                    top_next.nxt = top_reg.nxt + 1'b1;
                    nr_next      = cand_r;
                    nc_next      = cand_c;
                    wr_next      = cand_wr;
                    wc_next      = cand_wc;
                    vis_raddr    = cand_r[RA:1];
                    if (dir_ok)
                    begin
                        state_next = S_VIS;
                    end
                end
            end
            S_POPRD:
            begin
                top_next   = stk_q;
                state_next = S_CHECK;
            end
            S_VIS:
            begin
                if (vis_hit)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    vis_we    = 1'b1;
                    vis_wdata = (vis_vld_reg[nr_reg[RA:1]] ? vis_q : '0)
                              | (mrc_pkg::ROOM_DIM'(1) << nc_reg[RA:1]);
                    vis_vld_next[nr_reg[RA:1]] = 1'b1;
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                // Open the wall, push the old top and make the new room the top.
                cv_we    = 1'b1;
                cv_wdata = (cv_vld_reg[wr_reg] ? cv_q : '0)
                         | (mrc_pkg::MAX_SIZE'(1) << wc_reg);
                cv_vld_next[wr_reg] = 1'b1;
                stk_ctl.we     = 1'b1;
                level_next     = level_reg + 1'b1;
                top_next.row   = nr_reg;
                top_next.col   = nc_reg;
                top_next.order = mrc_pkg::shuffle(req_reg.rand_first,
                                     req_reg.rand_second, req_reg.rand_third);
                top_next.nxt   = '0;
                rsp_next.wall_row = wr_reg;
                rsp_next.wall_col = wc_reg;
                rsp_next.room_row = nr_reg;
                rsp_next.room_col = nc_reg;
                rsp_next.carved   = 1'b1;
                rsp_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end
            S_RDCELL:
            begin
                if (req_reg.read_row >= n || req_reg.read_col >= n)
                begin
                    rsp_next.cell_is_wall = 1'b1;
                end
                else
                begin
                    rsp_next.cell_is_wall = !(room_open || wall_open);
                end
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            vis_vld_reg   <= '0;
            cv_vld_reg    <= '0;
            started_reg   <= 1'b0;
            size_reg      <= 6'(mrc_pkg::RESET_SIZE);
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            rsp_valid_reg <= rsp_valid_next;
            vis_vld_reg   <= vis_vld_next;
            cv_vld_reg    <= cv_vld_next;
            started_reg   <= started_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        top_reg    <= top_next;
        nstart_reg <= nstart_next;
        nr_reg     <= nr_next;
        nc_reg     <= nc_next;
        wr_reg     <= wr_next;
        wc_reg     <= wc_next;
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_q <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cv_we)
        begin
            cv_mem[cv_waddr] <= cv_wdata;
        end
        cv_q <= cv_mem[cv_raddr];
    end

`ifndef NO_ASSERTIONS
    a_ready_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid)
        else $error("new word taken while a result is pending");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= (SA+1)'(mrc_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    a_carve_reports: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CARVE |=> rsp_valid && rsp.carved && (state_reg == S_IDLE))
        else $error("carve step did not produce a carved result");

    a_top_is_room: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg != '0) && (state_reg == S_CHECK) |-> top_reg.row[0] && top_reg.col[0])
        else $error("top of stack is not a room");
`endif

endmodule
